FILE: rtl/hsba_pkg.sv
// Shared constants, types and tables for the HSL band adjuster.
package hsba_pkg;

   localparam int NUM_BANDS            = 8;
   localparam int BAND_IDX_W           = $clog2(NUM_BANDS);
   localparam int WEIGHT_FRAC_BITS_DEF = 16;
   localparam int TABLE_FRAC_BITS      = 16;
   localparam int TABLE_LEN            = 45;
   localparam int QUOT_BITS            = 9;
   localparam int HUE_MAX              = 180;
   localparam int BYTE_MAX             = 255;
   localparam int HALF_TURN            = 180;
   localparam int FULL_TURN            = 360;
   localparam int HUE_LIM              = 120;
   localparam int SL_LIM               = 127;
   localparam int HUE_SCALE            = 8;
   localparam int LUM_SCALE            = 254;
   localparam int SAT_SCALE            = 127;
   localparam int CSR_W                = 24;

   // Pixel as it travels: raw bytes plus hue folded into 0..179
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] light;
      logic [7:0] sat;
      logic [7:0] hue_norm;
   } pix_type;

   // Per-request flags carried alongside the divider
   typedef struct packed {
      pix_type pix;
      logic    fallback;
      logic    np_hue;
      logic    np_light;
      logic    np_sat;
   } side_type;

   // Band centers in degrees
   function automatic logic [8:0] band_center(input logic [BAND_IDX_W-1:0] idx);
      logic [8:0] c;
      unique case (idx)
         3'd0:    c = 9'd0;
         3'd1:    c = 9'd45;
         3'd2:    c = 9'd90;
         3'd3:    c = 9'd150;
         3'd4:    c = 9'd195;
         3'd5:    c = 9'd240;
         3'd6:    c = 9'd285;
         default: c = 9'd315;
      endcase
      return c;
   endfunction

   // Raised-cosine weight, Q1.16, by angular distance in degrees
   function automatic logic [16:0] cos_weight(input logic [5:0] d);
      logic [16:0] w;
      unique case (d)
         6'd0:  w = 17'd65536;  6'd1:  w = 17'd65456;  6'd2:  w = 17'd65217;
         6'd3:  w = 17'd64820;  6'd4:  w = 17'd64267;  6'd5:  w = 17'd63560;
         6'd6:  w = 17'd62703;  6'd7:  w = 17'd61700;  6'd8:  w = 17'd60557;
         6'd9:  w = 17'd59278;  6'd10: w = 17'd57870;  6'd11: w = 17'd56339;
         6'd12: w = 17'd54694;  6'd13: w = 17'd52942;  6'd14: w = 17'd51092;
         6'd15: w = 17'd49152;  6'd16: w = 17'd47133;  6'd17: w = 17'd45043;
         6'd18: w = 17'd42894;  6'd19: w = 17'd40695;  6'd20: w = 17'd38458;
         6'd21: w = 17'd36193;  6'd22: w = 17'd33912;  6'd23: w = 17'd31624;
         6'd24: w = 17'd29343;  6'd25: w = 17'd27078;  6'd26: w = 17'd24841;
         6'd27: w = 17'd22642;  6'd28: w = 17'd20493;  6'd29: w = 17'd18403;
         6'd30: w = 17'd16384;  6'd31: w = 17'd14444;  6'd32: w = 17'd12594;
         6'd33: w = 17'd10842;  6'd34: w = 17'd9197;   6'd35: w = 17'd7666;
         6'd36: w = 17'd6258;   6'd37: w = 17'd4979;   6'd38: w = 17'd3836;
         6'd39: w = 17'd2833;   6'd40: w = 17'd1976;   6'd41: w = 17'd1269;
         6'd42: w = 17'd716;    6'd43: w = 17'd319;    6'd44: w = 17'd80;
         default: w = '0;
      endcase
      return w;
   endfunction

   // Hue shift field, clamped to +-120 quarter-degrees
   function automatic logic signed [7:0] hue_field(input logic [CSR_W-1:0] r);
      logic signed [7:0] x;
      x = $signed(r[7:0]);
      if (x > 8'sd120) x = 8'(HUE_LIM);
      else if (x < -8'sd120) x = -8'(HUE_LIM);
      return x;
   endfunction

   // Saturation / lightness field, -128 folds to -127
   function automatic logic signed [7:0] sl_field(input logic [7:0] v);
      logic signed [7:0] x;
      x = $signed(v);
      if (x < -8'sd127) x = -8'(SL_LIM);
      return x;
   endfunction

endpackage

FILE: rtl/hsba_front.sv
// Front end: folds hue and derives the eight band weights.
module hsba_front #(
   parameter int WEIGHT_FRAC_BITS = hsba_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [7:0]                in_hue,
   input  logic [7:0]                in_light,
   input  logic [7:0]                in_sat,
   output logic                      out_valid,
   output hsba_pkg::pix_type         out_pix,
   output logic [WEIGHT_FRAC_BITS:0] out_weight [hsba_pkg::NUM_BANDS]
);
   import hsba_pkg::*;

   localparam int WW  = WEIGHT_FRAC_BITS + 1;
   localparam int UP  = (WEIGHT_FRAC_BITS >= TABLE_FRAC_BITS) ?
                        WEIGHT_FRAC_BITS - TABLE_FRAC_BITS : 0;
   localparam int DN  = (WEIGHT_FRAC_BITS < TABLE_FRAC_BITS) ?
                        TABLE_FRAC_BITS - WEIGHT_FRAC_BITS : 0;
   localparam int RND = (DN > 0) ? (1 << (DN - 1)) : 0;
   localparam int THR = (1 << WEIGHT_FRAC_BITS) / 1000;

   logic          valid_ff;
   pix_type       pix_ff, pix_in;
   logic [8:0]    deg;
   logic [WW-1:0] weight_ff [NUM_BANDS];
   logic [WW-1:0] weight_in [NUM_BANDS];

   // hue modulo 180, then in degrees
   always_comb begin
      pix_in.hue      = in_hue;
      pix_in.light    = in_light;
      pix_in.sat      = in_sat;
      pix_in.hue_norm = (in_hue >= 8'(HUE_MAX)) ? in_hue - 8'(HUE_MAX) : in_hue;
      deg             = {pix_in.hue_norm, 1'b0};
   end

   // per band: wrapped distance, table weight, rescale, drop tiny weights
   for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
      logic [8:0]    center, diff, ang_dist;
      logic [16:0]   tab;
      logic [17:0]   rnd;
      logic [WW-1:0] ws;
      always_comb begin
         center   = band_center(BAND_IDX_W'(b));
         diff     = (deg >= center) ? deg - center : center - deg;
         ang_dist = (diff > 9'(HALF_TURN)) ? 9'(FULL_TURN) - diff : diff;
         tab      = (ang_dist < 9'(TABLE_LEN)) ? cos_weight(ang_dist[5:0]) : '0;
         rnd      = {1'b0, tab} + 18'(RND);
         if (DN == 0) begin
            ws = WW'(tab) << UP;
         end else begin
            ws = WW'(rnd >> DN);
         end
         weight_in[b] = (ws > WW'(THR)) ? ws : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pix_ff    <= pix_in;
      weight_ff <= weight_in;
   end

   assign out_valid  = valid_ff;
   assign out_pix    = pix_ff;
   assign out_weight = weight_ff;

endmodule

FILE: rtl/hsba_queue.sv
// Two-entry request queue between the front end and the arithmetic back end.
module hsba_queue #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   output logic          pop_valid,
   output logic [DW-1:0] pop_data
);
   import hsba_pkg::*;

   logic [DW-1:0] mem [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          pop;

   // back end always drains, so a nonempty head pops at once
   always_comb begin
      pop       = (count_ff != 2'd0);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = pop;
   assign pop_data  = mem[rd_ptr_ff];

endmodule

FILE: rtl/hsba_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module hsba_div #(
   parameter int DW = 40,
   parameter int QW = hsba_pkg::QUOT_BITS
) (
   input  logic          clock,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);
   import hsba_pkg::*;

   logic [DW-1:0] r_ff [QW];
   logic [DW-1:0] d_ff [QW];
   logic [QW-1:0] q_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int K = QW - 1 - i;
      logic [DW-1:0] r_in, d_in, sub;
      logic [QW-1:0] q_in;
      if (i == 0) begin : g_first
         assign r_in = num;
         assign d_in = den;
         assign q_in = '0;
      end else begin : g_next
         assign r_in = r_ff[i-1];
         assign d_in = d_ff[i-1];
         assign q_in = q_ff[i-1];
      end
      assign sub = d_in << K;

      // compare-subtract for quotient bit K
      always_ff @(posedge clock) begin
         if (r_in >= sub) begin
            r_ff[i] <= r_in - sub;
            q_ff[i] <= q_in | (QW'(1) << K);
         end else begin
            r_ff[i] <= r_in;
            q_ff[i] <= q_in;
         end
         d_ff[i] <= d_in;
      end
   end

   assign quo = q_ff[QW-1];

endmodule

FILE: rtl/hsba_back.sv
// Back end: weighted sums, ratio setup, three dividers, rounding and clamp.
module hsba_back #(
   parameter int WEIGHT_FRAC_BITS = hsba_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  hsba_pkg::pix_type           in_pix,
   input  logic [WEIGHT_FRAC_BITS:0]   in_weight [hsba_pkg::NUM_BANDS],
   input  logic [hsba_pkg::CSR_W-1:0]  band_reg  [hsba_pkg::NUM_BANDS],
   output logic                        out_valid,
   output logic [7:0]                  out_hue,
   output logic [7:0]                  out_light,
   output logic [7:0]                  out_sat
);
   import hsba_pkg::*;

   localparam int W    = WEIGHT_FRAC_BITS;
   localparam int WW   = W + 1;
   localparam int PW   = W + 10;
   localparam int SW   = W + 12;
   localparam int TWW  = W + 4;
   localparam int AW   = W + 12;
   localparam int NW   = W + 22;
   localparam int DENW = W + 12;
   localparam int DVW  = W + 24;
   localparam int THR  = (1 << W) / 1000;
   localparam int QW   = QUOT_BITS;

   logic [6:0] vld_ff;

   // S1: per-band products
   pix_type              pix1_ff;
   logic [WW-1:0]        w1_ff  [NUM_BANDS];
   logic signed [PW-1:0] ph1_ff [NUM_BANDS];
   logic signed [PW-1:0] ps1_ff [NUM_BANDS];
   logic signed [PW-1:0] pl1_ff [NUM_BANDS];

   always_ff @(posedge clock) begin
      pix1_ff <= in_pix;
      for (int b = 0; b < NUM_BANDS; b++) begin
         w1_ff[b]  <= in_weight[b];
         ph1_ff[b] <= $signed({1'b0, in_weight[b]}) * hue_field(band_reg[b]);
         ps1_ff[b] <= $signed({1'b0, in_weight[b]}) * sl_field(band_reg[b][15:8]);
         pl1_ff[b] <= $signed({1'b0, in_weight[b]}) * sl_field(band_reg[b][23:16]);
      end
   end

   // S2: sums of four
   pix_type              pix2_ff;
   logic [W+2:0]         tw2_ff [2];
   logic signed [SW-1:0] th2_ff [2];
   logic signed [SW-1:0] ts2_ff [2];
   logic signed [SW-1:0] tl2_ff [2];

   always_ff @(posedge clock) begin
      pix2_ff <= pix1_ff;
      for (int h = 0; h < 2; h++) begin
         tw2_ff[h] <= (W+3)'(w1_ff[4*h]) + (W+3)'(w1_ff[4*h+1])
                    + (W+3)'(w1_ff[4*h+2]) + (W+3)'(w1_ff[4*h+3]);
         th2_ff[h] <= SW'(ph1_ff[4*h]) + SW'(ph1_ff[4*h+1])
                    + SW'(ph1_ff[4*h+2]) + SW'(ph1_ff[4*h+3]);
         ts2_ff[h] <= SW'(ps1_ff[4*h]) + SW'(ps1_ff[4*h+1])
                    + SW'(ps1_ff[4*h+2]) + SW'(ps1_ff[4*h+3]);
         tl2_ff[h] <= SW'(pl1_ff[4*h]) + SW'(pl1_ff[4*h+1])
                    + SW'(pl1_ff[4*h+2]) + SW'(pl1_ff[4*h+3]);
      end
   end

   // S3: totals
   pix_type              pix3_ff;
   logic [TWW-1:0]       tw3_ff;
   logic signed [SW-1:0] th3_ff, ts3_ff, tl3_ff;

   always_ff @(posedge clock) begin
      pix3_ff <= pix2_ff;
      tw3_ff  <= TWW'(tw2_ff[0]) + TWW'(tw2_ff[1]);
      th3_ff  <= th2_ff[0] + th2_ff[1];
      ts3_ff  <= ts2_ff[0] + ts2_ff[1];
      tl3_ff  <= tl2_ff[0] + tl2_ff[1];
   end

   // S4: base times weight, headroom times sum
   logic [7:0]           m_light, m_sat;
   pix_type              pix4_ff;
   logic                 fb4_ff;
   logic [TWW-1:0]       tw4_ff;
   logic signed [NW-1:0] th4_ff, ml4_ff, ms4_ff;
   logic [AW-1:0]        ah4_ff, al4_ff, as4_ff;

   always_comb begin
      m_light = (tl3_ff > 0) ? 8'(BYTE_MAX) - pix3_ff.light : pix3_ff.light;
      m_sat   = (ts3_ff > 0) ? 8'(BYTE_MAX) - pix3_ff.sat   : pix3_ff.sat;
   end

   always_ff @(posedge clock) begin
      pix4_ff <= pix3_ff;
      fb4_ff  <= !(tw3_ff > TWW'(THR));
      tw4_ff  <= tw3_ff;
      th4_ff  <= NW'(th3_ff);
      ah4_ff  <= AW'(pix3_ff.hue_norm) * AW'(tw3_ff);
      al4_ff  <= AW'(pix3_ff.light) * AW'(tw3_ff);
      as4_ff  <= AW'(pix3_ff.sat) * AW'(tw3_ff);
      ml4_ff  <= $signed({1'b0, m_light}) * tl3_ff;
      ms4_ff  <= $signed({1'b0, m_sat}) * ts3_ff;
   end

   // S5: numerators, denominators, hue period
   pix_type              pix5_ff;
   logic                 fb5_ff;
   logic signed [NW-1:0] nh5_ff, nl5_ff, ns5_ff, per5_ff;
   logic [DENW-1:0]      dh5_ff, dl5_ff, ds5_ff;

   always_ff @(posedge clock) begin
      pix5_ff <= pix4_ff;
      fb5_ff  <= fb4_ff;
      nh5_ff  <= $signed(NW'(ah4_ff) * NW'(HUE_SCALE)) + th4_ff;
      nl5_ff  <= $signed(NW'(al4_ff) * NW'(LUM_SCALE)) + ml4_ff;
      ns5_ff  <= $signed(NW'(as4_ff) * NW'(SAT_SCALE)) + ms4_ff;
      per5_ff <= $signed(NW'(tw4_ff) * NW'(HUE_SCALE * HUE_MAX));
      dh5_ff  <= DENW'(tw4_ff) * DENW'(HUE_SCALE);
      dl5_ff  <= DENW'(tw4_ff) * DENW'(LUM_SCALE);
      ds5_ff  <= DENW'(tw4_ff) * DENW'(SAT_SCALE);
   end

   // S6: hue wrap into one period
   pix_type              pix6_ff;
   logic                 fb6_ff;
   logic signed [NW-1:0] nh6_ff, nl6_ff, ns6_ff;
   logic [DENW-1:0]      dh6_ff, dl6_ff, ds6_ff;

   always_ff @(posedge clock) begin
      pix6_ff <= pix5_ff;
      fb6_ff  <= fb5_ff;
      priority if (nh5_ff < 0) begin
         nh6_ff <= nh5_ff + per5_ff;
      end else if (nh5_ff >= per5_ff) begin
         nh6_ff <= nh5_ff - per5_ff;
      end else begin
         nh6_ff <= nh5_ff;
      end
      nl6_ff <= nl5_ff;
      ns6_ff <= ns5_ff;
      dh6_ff <= dh5_ff;
      dl6_ff <= dl5_ff;
      ds6_ff <= ds5_ff;
   end

   // S7: round-half-up operands 2n+d over 2d
   side_type       side7_ff;
   logic [DVW-1:0] nh7_ff, nl7_ff, ns7_ff, dh7_ff, dl7_ff, ds7_ff;

   always_ff @(posedge clock) begin
      side7_ff.pix      <= pix6_ff;
      side7_ff.fallback <= fb6_ff;
      side7_ff.np_hue   <= (nh6_ff <= 0);
      side7_ff.np_light <= (nl6_ff <= 0);
      side7_ff.np_sat   <= (ns6_ff <= 0);
      nh7_ff <= (DVW'(nh6_ff) << 1) + DVW'(dh6_ff);
      nl7_ff <= (DVW'(nl6_ff) << 1) + DVW'(dl6_ff);
      ns7_ff <= (DVW'(ns6_ff) << 1) + DVW'(ds6_ff);
      dh7_ff <= DVW'(dh6_ff) << 1;
      dl7_ff <= DVW'(dl6_ff) << 1;
      ds7_ff <= DVW'(ds6_ff) << 1;
   end

   // dividers
   logic [QW-1:0] q_hue, q_light, q_sat;

   hsba_div #(.DW(DVW), .QW(QW)) u_div_hue (
      .clock (clock), .num (nh7_ff), .den (dh7_ff), .quo (q_hue)
   );
   hsba_div #(.DW(DVW), .QW(QW)) u_div_light (
      .clock (clock), .num (nl7_ff), .den (dl7_ff), .quo (q_light)
   );
   hsba_div #(.DW(DVW), .QW(QW)) u_div_sat (
      .clock (clock), .num (ns7_ff), .den (ds7_ff), .quo (q_sat)
   );

   // side info delayed to match the dividers
   side_type      sd_ff [QW];
   logic [QW-1:0] sv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         sv_ff  <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], in_valid};
         sv_ff  <= {sv_ff[QW-2:0], vld_ff[6]};
      end
      sd_ff[0] <= side7_ff;
      for (int k = 1; k < QW; k++) begin
         sd_ff[k] <= sd_ff[k-1];
      end
   end

   // output register: clamp, zero on non-positive, pass-through fallback
   side_type   sd;
   logic       out_valid_ff;
   logic [7:0] hue_ff, light_ff, sat_ff, hue_in, light_in, sat_in;

   always_comb begin
      sd = sd_ff[QW-1];
      if (sd.fallback) begin
         hue_in   = (sd.pix.hue > 8'(HUE_MAX)) ? 8'(HUE_MAX) : sd.pix.hue;
         light_in = sd.pix.light;
         sat_in   = sd.pix.sat;
      end else begin
         hue_in   = sd.np_hue ? 8'd0 :
                    (q_hue > QW'(HUE_MAX)) ? 8'(HUE_MAX) : q_hue[7:0];
         light_in = sd.np_light ? 8'd0 :
                    (q_light > QW'(BYTE_MAX)) ? 8'(BYTE_MAX) : q_light[7:0];
         sat_in   = sd.np_sat ? 8'd0 :
                    (q_sat > QW'(BYTE_MAX)) ? 8'(BYTE_MAX) : q_sat[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= sv_ff[QW-1];
      end
      hue_ff   <= hue_in;
      light_ff <= light_in;
      sat_ff   <= sat_in;
   end

   assign out_valid = out_valid_ff;
   assign out_hue   = hue_ff;
   assign out_light = light_ff;
   assign out_sat   = sat_ff;

endmodule

FILE: rtl/hsl_band_adjust.sv
// Top level of the HSL band adjuster: band registers, front, queue, back.
//
// Takes one HLS pixel per request and returns the adjusted pixel. A request
// is taken in every clock cycle (busy never rises) and its result appears
// on the rsp_ ports for one cycle, marked by rsp_strobe, in request order,
// after the front-end weight register, the queue, the summing and ratio
// setup stages, the one-bit-per-stage dividers and the output register. The
// receiver cannot stall the block. The user must write the band registers
// through csr_ only while no request is in flight; the block itself does
// not enforce this. The band registers reset to zero.
module hsl_band_adjust #(
   parameter int WEIGHT_FRAC_BITS = hsba_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [7:0]                      req_hue_half,
   input  logic [7:0]                      req_light_in,
   input  logic [7:0]                      req_sat_in,
   output logic                            rsp_strobe,
   output logic [7:0]                      rsp_hue_out,
   output logic [7:0]                      rsp_light_out,
   output logic [7:0]                      rsp_sat_out,
   input  logic                            csr_write_en,
   input  logic [hsba_pkg::BAND_IDX_W-1:0] csr_index,
   input  logic [hsba_pkg::CSR_W-1:0]      csr_write_data
);
   import hsba_pkg::*;

   localparam int WW      = WEIGHT_FRAC_BITS + 1;
   localparam int PIXW    = $bits(pix_type);
   localparam int QDW     = PIXW + NUM_BANDS * WW;
   localparam int LATENCY = 10 + QUOT_BITS;

   logic             accept;
   logic [CSR_W-1:0] band_reg_ff [NUM_BANDS];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // band adjustment registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            band_reg_ff[b] <= '0;
         end
      end else if (csr_write_en) begin
         band_reg_ff[csr_index] <= csr_write_data;
      end
   end

   // front end
   logic          f_valid;
   pix_type       f_pix;
   logic [WW-1:0] f_weight [NUM_BANDS];

   hsba_front #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_hue     (req_hue_half),
      .in_light   (req_light_in),
      .in_sat     (req_sat_in),
      .out_valid  (f_valid),
      .out_pix    (f_pix),
      .out_weight (f_weight)
   );

   // pack for the queue
   logic [QDW-1:0] q_in, q_out;
   logic           q_valid;
   pix_type        b_pix;
   logic [WW-1:0]  b_weight [NUM_BANDS];

   always_comb begin
      q_in[QDW-1 -: PIXW] = f_pix;
      for (int b = 0; b < NUM_BANDS; b++) begin
         q_in[b*WW +: WW] = f_weight[b];
      end
      b_pix = q_out[QDW-1 -: PIXW];
      for (int b = 0; b < NUM_BANDS; b++) begin
         b_weight[b] = q_out[b*WW +: WW];
      end
   end

   hsba_queue #(.DW(QDW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (q_in),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   // back end
   hsba_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_pix    (b_pix),
      .in_weight (b_weight),
      .band_reg  (band_reg_ff),
      .out_valid (rsp_strobe),
      .out_hue   (rsp_hue_out),
      .out_light (rsp_light_out),
      .out_sat   (rsp_sat_out)
   );

`ifndef NO_ASSERTIONS
   // every request produces a result after the fixed latency
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("request did not produce a result in time");

   // no result without a matching request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without request");

   // adjusted hue stays in range
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_hue_out <= 8'(HUE_MAX)))
      else $error("hue out of range");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the HSL band adjuster.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hsba_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 30;
   localparam int RESET_CYCLES = 12;
   localparam int RAND_PHASES  = 8;
   localparam int RAND_PER_SET = 115;

   typedef enum logic [1:0] {ITEM_PIXEL, ITEM_CSR, ITEM_SETTLE} item_kind_type;

   // One entry of the stimulus queue
   typedef struct {
      item_kind_type kind;
      logic [7:0] hue;
      logic [7:0] light;
      logic [7:0] sat;
      logic [BAND_IDX_W-1:0] idx;
      logic [CSR_W-1:0] data;
   } stim_item_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] light;
      logic [7:0] sat;
   } hsl_pix_type;

   // Raised-cosine weight, Q1.16, by distance in degrees
   localparam int unsigned WEIGHT_LUT [45] = '{
      65536, 65456, 65217, 64820, 64267, 63560, 62703, 61700, 60557, 59278,
      57870, 56339, 54694, 52942, 51092, 49152, 47133, 45043, 42894, 40695,
      38458, 36193, 33912, 31624, 29343, 27078, 24841, 22642, 20493, 18403,
      16384, 14444, 12594, 10842,  9197,  7666,  6258,  4979,  3836,  2833,
       1976,  1269,   716,   319,    80};
   localparam int CENTER_DEG [8] = '{0, 45, 90, 150, 195, 240, 285, 315};
   localparam longint WEIGHT_ONE = 64'd1 << WEIGHT_FRAC_BITS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_hue_half = '0, req_light_in = '0, req_sat_in = '0;
   logic rsp_strobe;
   logic [7:0] rsp_hue_out, rsp_light_out, rsp_sat_out;
   logic csr_write_en = 1'b0;
   logic [BAND_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_write_data = '0;

   stim_item_type pending_q[$];
   hsl_pix_type   adjusted_q[$];
   logic [CSR_W-1:0] band_copy [NUM_BANDS];
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned csr_writes = 0;
   int unsigned results_seen = 0;
   int gap_count = 0;
   int settle_count = 0;

   hsl_band_adjust DUT (.*);

   always #6 clock = ~clock;

   // Signed byte field of a band register, clamped to +-lim
   function automatic longint band_field(logic [CSR_W-1:0] r, int pos, longint lim);
      longint x = longint'(r[pos +: 8]);
      if (x >= 128) x -= 256;
      if (x > lim) x = lim;
      if (x < -lim) x = -lim;
      return x;
   endfunction

   // Round num/den to nearest, ties up, clamped to maxv; non-positive gives 0
   function automatic longint round_div(longint num, longint den, longint maxv);
      longint q;
      if (num <= 0 || den <= 0) return 0;
      q = (2 * num + den) / (2 * den);
      return (q > maxv) ? maxv : q;
   endfunction

   // Move base toward 255 or 0 by sum/den
   function automatic longint move_toward(longint base, longint sum, longint den);
      longint m = (sum > 0) ? (255 - base) : base;
      return round_div(base * den + m * sum, den, 255);
   endfunction

   // Expected adjusted pixel under the current band settings
   function automatic hsl_pix_type adjust_pixel(logic [7:0] hh, logic [7:0] l, logic [7:0] s);
      longint hn, deg, d, w, den, period, num;
      longint tw = 0, th = 0, ts = 0, tl = 0;
      hsl_pix_type p;
      hn = (hh >= 180) ? longint'(hh) - 180 : longint'(hh);
      deg = 2 * hn;
      for (int b = 0; b < NUM_BANDS; b++) begin
         d = deg - CENTER_DEG[b];
         if (d < 0) d = -d;
         if (d > 180) d = 360 - d;
         if (d < 45) begin
            w = WEIGHT_LUT[d];
            if (w * 1000 > WEIGHT_ONE) begin
               th += w * band_field(band_copy[b], 0, 120);
               ts += w * band_field(band_copy[b], 8, 127);
               tl += w * band_field(band_copy[b], 16, 127);
               tw += w;
            end
         end
      end
      if (tw * 1000 > WEIGHT_ONE) begin
         den = 8 * tw;
         period = 180 * den;
         num = hn * den + th;
         if (num < 0) num += period;
         else if (num >= period) num -= period;
         p.hue   = 8'(round_div(num, den, 180));
         p.light = 8'(move_toward(longint'(l), tl, 254 * tw));
         p.sat   = 8'(move_toward(longint'(s), ts, 127 * tw));
      end else begin
         p.hue   = (hh > 180) ? 8'd180 : hh;
         p.light = l;
         p.sat   = s;
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // Stimulus helpers: queue a pixel, a register write, a settle point
   task automatic add_pixel(logic [7:0] h, logic [7:0] l, logic [7:0] s);
      stim_item_type it;
      it.kind = ITEM_PIXEL; it.hue = h; it.light = l; it.sat = s; it.idx = '0; it.data = '0;
      pending_q.push_back(it);
   endtask

   task automatic add_setting(logic [CSR_W-1:0] val [NUM_BANDS]);
      stim_item_type it;
      it.kind = ITEM_SETTLE; it.hue = '0; it.light = '0; it.sat = '0; it.idx = '0; it.data = '0;
      pending_q.push_back(it);
      for (int i = 0; i < NUM_BANDS; i++) begin
         it.kind = ITEM_CSR; it.idx = BAND_IDX_W'(i); it.data = val[i];
         pending_q.push_back(it);
      end
   endtask

   function automatic logic [7:0] rand_field();
      logic [7:0] extremes [6] = '{8'h80, 8'h81, 8'h7F, 8'h78, 8'h88, 8'h00};
      if ($urandom_range(0, 3) == 0) return extremes[$urandom_range(0, 5)];
      return 8'($urandom);
   endfunction

   // Driver: holds start until accepted, then waits a random gap
   always @(posedge clock) begin
      logic nxt_start, nxt_we;
      nxt_start = start;
      nxt_we = 1'b0;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) begin
            adjusted_q.push_back(adjust_pixel(req_hue_half, req_light_in, req_sat_in));
            pixels_sent++;
            nxt_start = 1'b0;
         end
         if (!nxt_start) begin
            if (gap_count > 0) begin
               gap_count--;
            end else if (pending_q.size() > 0) begin
               case (pending_q[0].kind)
                  ITEM_PIXEL: begin
                     req_hue_half <= pending_q[0].hue;
                     req_light_in <= pending_q[0].light;
                     req_sat_in <= pending_q[0].sat;
                     nxt_start = 1'b1;
                     gap_count = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                     void'(pending_q.pop_front());
                  end
                  ITEM_CSR: begin
                     csr_index <= pending_q[0].idx;
                     csr_write_data <= pending_q[0].data;
                     nxt_we = 1'b1;
                     band_copy[pending_q[0].idx] = pending_q[0].data;
                     csr_writes++;
                     void'(pending_q.pop_front());
                  end
                  default: begin
                     // block idle: wait out the pipeline before reconfiguring
                     if (adjusted_q.size() == 0) begin
                        if (settle_count >= SETTLE_WAIT) begin
                           settle_count = 0;
                           void'(pending_q.pop_front());
                        end else begin
                           settle_count++;
                        end
                     end
                  end
               endcase
            end
         end
      end
      start <= nxt_start;
      csr_write_en <= nxt_we;
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      hsl_pix_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (adjusted_q.size() == 0) begin
            report_mismatch("unexpected result, results vs requests",
                            int'(results_seen), int'(pixels_sent));
         end else begin
            want = adjusted_q.pop_front();
            if (rsp_hue_out !== want.hue) report_mismatch("hue_out", rsp_hue_out, want.hue);
            if (rsp_light_out !== want.light)
               report_mismatch("light_out", rsp_light_out, want.light);
            if (rsp_sat_out !== want.sat) report_mismatch("sat_out", rsp_sat_out, want.sat);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      logic [CSR_W-1:0] regs [NUM_BANDS];
      logic [7:0] hue_pts [8] = '{8'd0, 8'd180, 8'd179, 8'd22, 8'd75, 8'd120, 8'd200, 8'd255};
      for (int i = 0; i < NUM_BANDS; i++) band_copy[i] = '0;

      // Directed: reset settings, then all-max and all-min band settings
      for (int k = 0; k < 8; k++) add_pixel(hue_pts[k], (k % 2) ? 8'd255 : 8'd0, 8'(k * 37));
      for (int i = 0; i < NUM_BANDS; i++) regs[i] = 24'h7F7F7F;
      add_setting(regs);
      for (int k = 0; k < 8; k++) add_pixel(hue_pts[k], 8'(k * 36), (k % 2) ? 8'd0 : 8'd255);
      for (int i = 0; i < NUM_BANDS; i++) regs[i] = 24'h808080;
      add_setting(regs);
      for (int k = 0; k < 8; k++) add_pixel(hue_pts[k], (k < 4) ? 8'd255 : 8'd1, 8'(255 - k));

      // Random band settings, each with a batch of random pixels
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         for (int i = 0; i < NUM_BANDS; i++) regs[i] = {rand_field(), rand_field(), rand_field()};
         add_setting(regs);
         for (int k = 0; k < RAND_PER_SET; k++)
            add_pixel(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180)),
                      8'($urandom), 8'($urandom));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (!(pending_q.size() == 0 && !start && adjusted_q.size() == 0)) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      $display("Sent %0d pixels over %0d band settings, %0d register writes, %0d results.",
               pixels_sent, RAND_PHASES + 3, csr_writes, results_seen);
      if (error_count == 0 && adjusted_q.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/hsba_pkg.sv
rtl/hsba_front.sv
rtl/hsba_queue.sv
rtl/hsba_div.sv
rtl/hsba_back.sv
rtl/hsl_band_adjust.sv
test/testbench.sv
